// File: src/fwrl_pkg.sv
`timescale 1ns / 1ps

package fwrl_pkg;

  // Field and register widths
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned REQ_W     = 20;
  localparam int unsigned TOK_W     = 24;
  localparam int unsigned WIN_W     = 12;
  localparam int unsigned EXP_W     = 3;
  localparam int unsigned POW_W     = 8;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  // Register reset values
  localparam logic [REQ_W-1:0] REQ_LIMIT_RST = REQ_W'(500);
  localparam logic [TOK_W-1:0] TOK_LIMIT_RST = TOK_W'(150000);
  localparam logic [WIN_W-1:0] WIN_SEC_RST   = WIN_W'(60);

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_RECORD = 2'd1,
    OP_STATUS = 2'd2,
    OP_SPARE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    VERDICT_ADMIT   = 2'd0,
    VERDICT_BACKOFF = 2'd1,
    VERDICT_REQ     = 2'd2,
    VERDICT_TOK     = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    REG_REQUEST_LIMIT  = 2'd0,
    REG_TOKEN_LIMIT    = 2'd1,
    REG_WINDOW_SECONDS = 2'd2,
    REG_NONE           = 2'd3
  } reg_idx_t;

  // One accepted input beat
  typedef struct packed {
    logic [1:0]       opcode;
    logic [NOW_W-1:0] now_seconds;
    logic [TOK_W-1:0] est_tokens;
    logic [TOK_W-1:0] query_tokens;
    logic [TOK_W-1:0] reply_tokens;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [1:0]       verdict;
    logic [REQ_W-1:0] remaining_requests;
    logic [TOK_W-1:0] remaining_tokens;
    logic             tokens_unlimited;
    logic [CNT_W-1:0] refusal_count;
    logic [EXP_W-1:0] backoff_exponent;
  } result_t;

endpackage

// File: src/fixed_window_rate_limiter_top.sv
`timescale 1ns / 1ps
// An accepted input beat passes the input register, then the result register,
// to its result beat on out_valid. Throughput: one item per cycle unless stalled;
// the window, counter and backoff update is one combinational pass in between.
// A stalled result holds the input register; in_stall rises only then.
// Reset (rst_n low, synchronous) empties both registers, clears all window and
// backoff state and loads request_limit 500, token_limit 150000, window 60 s.
module fixed_window_rate_limiter_top
  import fwrl_pkg::*;
#(
  parameter int unsigned MAX_BACKOFF_EXP   = 5,
  parameter int unsigned MAX_DELAY_SECONDS = 30
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [NOW_W-1:0]  in_now_seconds,
  input  logic [TOK_W-1:0]  in_est_tokens,
  input  logic [TOK_W-1:0]  in_query_tokens,
  input  logic [TOK_W-1:0]  in_reply_tokens,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_verdict,
  output logic [REQ_W-1:0]  out_remaining_requests,
  output logic [TOK_W-1:0]  out_remaining_tokens,
  output logic              out_tokens_unlimited,
  output logic [CNT_W-1:0]  out_refusal_count,
  output logic [EXP_W-1:0]  out_backoff_exponent,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned DELAY_W = $clog2(MAX_DELAY_SECONDS + 1);
  localparam logic [EXP_W-1:0]   EXP_MAX   = EXP_W'(MAX_BACKOFF_EXP);
  localparam logic [POW_W-1:0]   DELAY_MAX = POW_W'(MAX_DELAY_SECONDS);
  localparam logic [CNT_W-1:0]   CNT_SAT   = {CNT_W{1'b1}};

  // Configuration registers
  logic [REQ_W-1:0] req_limit_r;
  logic [TOK_W-1:0] tok_limit_r;
  logic [WIN_W-1:0] win_sec_r;

  // Limiter state
  logic [NOW_W-1:0] win_start_r, win_start_nxt;
  logic [CNT_W-1:0] win_req_r, win_req_nxt;
  logic [CNT_W-1:0] win_tok_r, win_tok_nxt;
  logic [CNT_W-1:0] refusals_r, refusals_nxt;
  logic [EXP_W-1:0] bexp_r, bexp_nxt;
  logic [NOW_W-1:0] bend_r, bend_nxt;

  // Pipeline registers
  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res_nxt;

  logic    s1_adv;
  logic    in_fire;
  logic    cfg_wr;
  reg_idx_t cfg_idx;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    case (cfg_idx)
      REG_REQUEST_LIMIT:  prdata = DATA_W'(req_limit_r);
      REG_TOKEN_LIMIT:    prdata = DATA_W'(tok_limit_r);
      REG_WINDOW_SECONDS: prdata = DATA_W'(win_sec_r);
      default:            prdata = '0;
    endcase
  end

  // Write registers; zero request limit or window length is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_limit_r <= REQ_LIMIT_RST;
      tok_limit_r <= TOK_LIMIT_RST;
      win_sec_r   <= WIN_SEC_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_REQUEST_LIMIT: begin
          if (pwdata[REQ_W-1:0] != '0) req_limit_r <= pwdata[REQ_W-1:0];
        end
        REG_TOKEN_LIMIT: begin
          tok_limit_r <= pwdata[TOK_W-1:0];
        end
        REG_WINDOW_SECONDS: begin
          if (pwdata[WIN_W-1:0] != '0) win_sec_r <= pwdata[WIN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || s1_adv) begin
      s1_valid_r <= in_fire;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.opcode       <= in_opcode;
      s1_item_r.now_seconds  <= in_now_seconds;
      s1_item_r.est_tokens   <= in_est_tokens;
      s1_item_r.query_tokens <= in_query_tokens;
      s1_item_r.reply_tokens <= in_reply_tokens;
    end
  end

  // ---------------------------------------------------------------- item logic
  logic [NOW_W-1:0]  now;
  logic [NOW_W-1:0]  elapsed;
  logic              expire;
  logic [NOW_W-1:0]  ws_rot;
  logic [CNT_W-1:0]  wreq_rot, wtok_rot;
  logic [EXP_W-1:0]  bexp_rot;
  logic [NOW_W-1:0]  bend_rot;
  logic [NOW_W-1:0]  ahead;
  logic              backoff_on, req_hit, tok_hit;
  logic [CNT_W:0]    tok_need;
  verdict_t          verdict;
  logic              refuse;
  logic [EXP_W-1:0]  bexp_inc;
  logic [POW_W-1:0]  pow;
  logic [DELAY_W-1:0] delay;
  logic [TOK_W:0]    rec_tok;
  logic [CNT_W:0]    tok_sum;

  assign now = s1_item_r.now_seconds;

  always_comb begin
    // rotate the window
    elapsed  = now - win_start_r;
    expire   = elapsed >= NOW_W'(win_sec_r);
    ws_rot   = expire ? now : win_start_r;
    wreq_rot = expire ? '0 : win_req_r;
    wtok_rot = expire ? '0 : win_tok_r;
    bexp_rot = (expire && refusals_r == '0) ? '0 : bexp_r;
    bend_rot = (expire && refusals_r == '0) ? '0 : bend_r;

    // admission tests in priority order
    ahead      = bend_rot - now;
    backoff_on = (bend_rot != '0) && (ahead != '0) && !ahead[NOW_W-1];
    req_hit    = wreq_rot >= CNT_W'(req_limit_r);
    tok_need   = {1'b0, wtok_rot} + (CNT_W+1)'(s1_item_r.est_tokens);
    tok_hit    = (tok_limit_r != '0) && (tok_need > (CNT_W+1)'(tok_limit_r));

    if (backoff_on)   verdict = VERDICT_BACKOFF;
    else if (req_hit) verdict = VERDICT_REQ;
    else if (tok_hit) verdict = VERDICT_TOK;
    else              verdict = VERDICT_ADMIT;

    refuse = (opcode_t'(s1_item_r.opcode) == OP_CHECK) && (verdict != VERDICT_ADMIT);

    // backoff step on a refusal
    bexp_inc = (bexp_rot < EXP_MAX) ? bexp_rot + EXP_W'(1) : EXP_MAX;
    pow      = POW_W'(1) << bexp_inc;
    delay    = (pow > DELAY_MAX) ? DELAY_W'(DELAY_MAX) : DELAY_W'(pow);

    // record accumulation, saturating
    rec_tok = (TOK_W+1)'(s1_item_r.query_tokens) + (TOK_W+1)'(s1_item_r.reply_tokens);
    tok_sum = {1'b0, wtok_rot} + (CNT_W+1)'(rec_tok);

    win_start_nxt = ws_rot;
    win_req_nxt   = wreq_rot;
    win_tok_nxt   = wtok_rot;
    refusals_nxt  = refusals_r;
    bexp_nxt      = bexp_rot;
    bend_nxt      = bend_rot;

    case (opcode_t'(s1_item_r.opcode))
      OP_CHECK: begin
        if (refuse) begin
          refusals_nxt = (refusals_r == CNT_SAT) ? CNT_SAT : refusals_r + CNT_W'(1);
          bexp_nxt     = bexp_inc;
          bend_nxt     = now + NOW_W'(delay);
        end
      end
      OP_RECORD: begin
        win_req_nxt = (wreq_rot == CNT_SAT) ? CNT_SAT : wreq_rot + CNT_W'(1);
        win_tok_nxt = tok_sum[CNT_W] ? CNT_SAT : tok_sum[CNT_W-1:0];
      end
      default: ;
    endcase
  end

  // Build the result from the state after the item
  always_comb begin
    res_nxt.verdict = (opcode_t'(s1_item_r.opcode) == OP_CHECK) ? verdict : VERDICT_ADMIT;
    res_nxt.remaining_requests = (CNT_W'(req_limit_r) > win_req_nxt)
                               ? REQ_W'(CNT_W'(req_limit_r) - win_req_nxt) : '0;
    res_nxt.remaining_tokens   = (tok_limit_r != '0 && win_tok_nxt < CNT_W'(tok_limit_r))
                               ? TOK_W'(CNT_W'(tok_limit_r) - win_tok_nxt) : '0;
    res_nxt.tokens_unlimited   = (tok_limit_r == '0);
    res_nxt.refusal_count      = refusals_nxt;
    res_nxt.backoff_exponent   = bexp_nxt;
  end

  // Advance state once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= '0;
      win_req_r   <= '0;
      win_tok_r   <= '0;
      refusals_r  <= '0;
      bexp_r      <= '0;
      bend_r      <= '0;
    end else if (s1_valid_r && s1_adv) begin
      win_start_r <= win_start_nxt;
      win_req_r   <= win_req_nxt;
      win_tok_r   <= win_tok_nxt;
      refusals_r  <= refusals_nxt;
      bexp_r      <= bexp_nxt;
      bend_r      <= bend_nxt;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_verdict            = out_res_r.verdict;
  assign out_remaining_requests = out_res_r.remaining_requests;
  assign out_remaining_tokens   = out_res_r.remaining_tokens;
  assign out_tokens_unlimited   = out_res_r.tokens_unlimited;
  assign out_refusal_count      = out_res_r.refusal_count;
  assign out_backoff_exponent   = out_res_r.backoff_exponent;

  // ---------------------------------------------------------------- assertions
  a_exp_cap: assert property (@(posedge clk) disable iff (!rst_n)
    bexp_r <= EXP_MAX)
    else $error("backoff exponent above its cap");

  a_refuse_counts: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_adv && refuse |=> refusals_r != '0 && bend_r == $past(bend_nxt))
    else $error("refusal did not update refusal count or backoff end");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

  a_refused_check: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_adv && opcode_t'(s1_item_r.opcode) != OP_CHECK
      |=> out_verdict == VERDICT_ADMIT)
    else $error("nonzero verdict on a non-check item");

endmodule
